### rtl/stbs_pkg.sv
package stbs_pkg;

   // Default geometry of the table
   localparam int TABLE_DEPTH_DEFAULT = 256;
   localparam int ENTRY_WIDTH_DEFAULT = 32;

   // Fixed field widths of the channels
   localparam int INDEX_WIDTH = 8;
   localparam int KEY_WIDTH   = 32;
   localparam int COUNT_WIDTH = 9;

   // Search bounds run one-based up to count + 1, so one bit above the count
   localparam int BOUND_WIDTH = COUNT_WIDTH + 1;

   // Configuration port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   // Command queue between front and back; keep it a power of two
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   // Register select is paddr[2]: one register per 32-bit word
   typedef enum logic {
      CSR_ENTRIES_IN_USE = 1'b0,
      CSR_COMPARE_SIGNED = 1'b1
   } csr_reg_type;

   typedef struct packed {
      op_type                 op;
      logic [INDEX_WIDTH-1:0] index;
      logic [KEY_WIDTH-1:0]   key;
   } cmd_type;

endpackage

### rtl/stbs_if.sv
interface stbs_req_if;
   logic                             valid;
   logic                             ready;
   logic                             op;
   logic [stbs_pkg::INDEX_WIDTH-1:0] entry_index;
   logic [stbs_pkg::KEY_WIDTH-1:0]   key_value;

   modport source (output valid, output op, output entry_index, output key_value,
                   input ready);
   modport sink   (input valid, input op, input entry_index, input key_value,
                   output ready);
endinterface

interface stbs_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             found;
   logic [stbs_pkg::INDEX_WIDTH-1:0] match_index;

   modport source (output valid, output found, output match_index, input ready);
   modport sink   (input valid, input found, input match_index, output ready);
endinterface

### rtl/stbs_front.sv
module stbs_front #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   stbs_req_if.sink          req_bus,
   output logic              push_valid,
   input  logic              push_ready,
   output stbs_pkg::cmd_type push_cmd
);
   import stbs_pkg::*;

   logic                   valid_ff, valid_in;
   cmd_type                cmd_ff, cmd_in;
   logic                   accept;
   logic [INDEX_WIDTH-1:0] wrap_index;

   assign req_bus.ready = !valid_ff || push_ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Wrap the write index into the table: subtract shifted depth multiples
   always_comb begin
      wrap_index = req_bus.entry_index;
      for (int s = INDEX_WIDTH - 1; s >= 0; s--) begin
         if ((32'(TABLE_DEPTH) << s) <= 32'(wrap_index)) begin
            wrap_index = wrap_index - INDEX_WIDTH'(32'(TABLE_DEPTH) << s);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff && !push_ready;
      cmd_in   = cmd_ff;
      if (accept) begin
         valid_in     = 1'b1;
         cmd_in.op    = op_type'(req_bus.op);
         cmd_in.index = wrap_index;
         cmd_in.key   = req_bus.key_value;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

endmodule

### rtl/stbs_queue.sv
module stbs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  stbs_pkg::cmd_type push_cmd,
   output logic              pop_valid,
   input  logic              pop_ready,
   output stbs_pkg::cmd_type pop_cmd
);
   import stbs_pkg::*;

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_WIDTH:0]   fill_ff, fill_in;
   logic                 push, pop;

   assign push_ready = fill_ff != (PTR_WIDTH + 1)'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];

   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   // Pointers wrap on their own since the depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_WIDTH'(1) : rd_ptr_ff;
      fill_in   = fill_ff + (PTR_WIDTH + 1)'(push) - (PTR_WIDTH + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### rtl/stbs_back.sv
module stbs_back #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ENTRY_WIDTH = stbs_pkg::ENTRY_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  stbs_pkg::cmd_type                cmd,
   input  logic [stbs_pkg::COUNT_WIDTH-1:0] entries_in_use,
   input  logic                             compare_signed,
   stbs_rsp_if.source                       rsp_bus
);
   import stbs_pkg::*;

   localparam int ADDR_WIDTH = $clog2(TABLE_DEPTH);
   localparam logic [ENTRY_WIDTH-1:0] SIGN_MASK = ENTRY_WIDTH'(1) << (ENTRY_WIDTH - 1);

   typedef enum logic {
      ST_IDLE,
      ST_PROBE
   } state_type;

   state_type              state_ff, state_in;
   logic [BOUND_WIDTH-1:0] low_ff, low_in;
   logic [BOUND_WIDTH-1:0] high_ff, high_in;
   logic [BOUND_WIDTH-1:0] probe_ff, probe_in;
   logic [ENTRY_WIDTH-1:0] key_ff, key_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, found_in;
   logic [INDEX_WIDTH-1:0] match_ff, match_in;

   logic [ENTRY_WIDTH-1:0] table_mem [TABLE_DEPTH];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;
   logic [ADDR_WIDTH-1:0]  rd_addr;
   logic [BOUND_WIDTH-1:0] rd_probe;
   logic                   wr_en;

   logic [BOUND_WIDTH-1:0] count_sat;
   logic [BOUND_WIDTH:0]   sum_first, sum_lt, sum_gt;
   logic [BOUND_WIDTH-1:0] probe_first, next_lt, next_gt;
   logic [BOUND_WIDTH-1:0] low_next, high_next;
   logic [ENTRY_WIDTH-1:0] key_ord, entry_ord;
   logic                   key_eq, key_lt, slot_free;

   // Clamp the count to the table
   always_comb begin
      if (32'(entries_in_use) > 32'(TABLE_DEPTH)) begin
         count_sat = BOUND_WIDTH'(TABLE_DEPTH);
      end else begin
         count_sat = BOUND_WIDTH'(entries_in_use);
      end
   end

   // Candidate probe addresses for both outcomes, ahead of the compare
   always_comb begin
      sum_first   = (BOUND_WIDTH + 1)'(count_sat) + (BOUND_WIDTH + 1)'(1);
      probe_first = sum_first[BOUND_WIDTH:1] - BOUND_WIDTH'(1);
      sum_lt      = (BOUND_WIDTH + 1)'(low_ff) + (BOUND_WIDTH + 1)'(probe_ff);
      next_lt     = sum_lt[BOUND_WIDTH:1] - BOUND_WIDTH'(1);
      sum_gt      = (BOUND_WIDTH + 1)'(probe_ff) + (BOUND_WIDTH + 1)'(high_ff)
                    + (BOUND_WIDTH + 1)'(2);
      next_gt     = sum_gt[BOUND_WIDTH:1] - BOUND_WIDTH'(1);
   end

   // Flip the sign bits for a two's complement order
   always_comb begin
      key_ord   = key_ff ^ (compare_signed ? SIGN_MASK : '0);
      entry_ord = rd_data_ff ^ (compare_signed ? SIGN_MASK : '0);
      key_eq    = key_ff == rd_data_ff;
      key_lt    = key_ord < entry_ord;
      low_next  = key_lt ? low_ff : probe_ff + BOUND_WIDTH'(2);
      high_next = key_lt ? probe_ff : high_ff;
   end

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      probe_in     = probe_ff;
      key_in       = key_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      found_in     = found_ff;
      match_in     = match_ff;
      cmd_ready    = 1'b0;
      wr_en        = 1'b0;
      rd_probe     = probe_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_WRITE) begin
                  cmd_ready = 1'b1;
                  wr_en     = 1'b1;
               end else if (count_sat == '0) begin
                  if (slot_free) begin
                     cmd_ready    = 1'b1;
                     rsp_valid_in = 1'b1;
                     found_in     = 1'b0;
                     match_in     = '0;
                  end
               end else begin
                  cmd_ready = 1'b1;
                  key_in    = ENTRY_WIDTH'(cmd.key);
                  low_in    = BOUND_WIDTH'(1);
                  high_in   = count_sat;
                  probe_in  = probe_first;
                  rd_probe  = probe_first;
                  state_in  = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (key_eq) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  found_in     = 1'b1;
                  match_in     = INDEX_WIDTH'(probe_ff);
                  state_in     = ST_IDLE;
               end
            end else if (low_next > high_next) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  found_in     = 1'b0;
                  match_in     = '0;
                  state_in     = ST_IDLE;
               end
            end else begin
               low_in   = low_next;
               high_in  = high_next;
               probe_in = key_lt ? next_lt : next_gt;
               rd_probe = probe_in;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_addr = ADDR_WIDTH'(rd_probe);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[ADDR_WIDTH'(cmd.index)] <= ENTRY_WIDTH'(cmd.key);
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      high_ff  <= high_in;
      probe_ff <= probe_in;
      key_ff   <= key_in;
      found_ff <= found_in;
      match_ff <= match_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.found       = found_ff;
   assign rsp_bus.match_index = match_ff;

endmodule

### rtl/sorted_table_binary_search.sv
// Channel  Role    Beat payload                          Handshake
// req_bus  sink    op, entry_index, key_value            valid && ready
// rsp_bus  source  found, match_index                    valid && ready
// APB      slave   entries_in_use @0x0, compare_signed @0x4  psel/penable, pready high
//
// A write beat stores one word and gives no result. A search beat passes the front
// register and a queue slot before it reaches the back end, which takes it and issues
// the first read, then makes at most ceil(log2(count + 1)) probes. One probe per cycle
// is set by the registered read port of the table memory; the last probe waits while
// the result register is still full, and the next command is taken only when idle.
// Reset clears control state only; the table is undefined until written.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT,
   parameter int ENTRY_WIDTH = stbs_pkg::ENTRY_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   stbs_req_if.sink                            req_bus,
   stbs_rsp_if.source                          rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [stbs_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [stbs_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [stbs_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import stbs_pkg::*;

   // Configuration registers
   logic [COUNT_WIDTH-1:0] entries_ff, entries_in;
   logic                   signed_ff, signed_in;
   logic                   csr_wr;
   csr_reg_type            csr_sel;

   // Front to queue, queue to back
   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_sel = csr_reg_type'(paddr[2]);

   // Decode the write; software writes only while nothing is in flight
   always_comb begin
      entries_in = entries_ff;
      signed_in  = signed_ff;
      if (csr_wr) begin
         case (csr_sel)
            CSR_ENTRIES_IN_USE: entries_in = pwdata[COUNT_WIDTH-1:0];
            CSR_COMPARE_SIGNED: signed_in  = pwdata[0];
            default: begin
               entries_in = entries_ff;
            end
         endcase
      end
   end

   // Read back the selected register
   always_comb begin
      case (csr_sel)
         CSR_ENTRIES_IN_USE: prdata = CSR_DATA_WIDTH'(entries_ff);
         CSR_COMPARE_SIGNED: prdata = CSR_DATA_WIDTH'(signed_ff);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= '0;
         signed_ff  <= 1'b0;
      end else begin
         entries_ff <= entries_in;
         signed_ff  <= signed_in;
      end
   end

   // Accept beats, wrap the write index, hold one command
   stbs_front #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // Decouple the front from the probing back end
   stbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Table memory, probe sequencer and result register
   stbs_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (pop_valid),
      .cmd_ready      (pop_ready),
      .cmd            (pop_cmd),
      .entries_in_use (entries_ff),
      .compare_signed (signed_ff),
      .rsp_bus        (rsp_bus)
   );

   // A count write lands in the register on the next cycle
   a_count_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_sel == CSR_ENTRIES_IN_USE |=> entries_ff == $past(pwdata[COUNT_WIDTH-1:0]))
      else $error("entries_in_use write lost");

   // A compare mode write lands in the register on the next cycle
   a_signed_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_sel == CSR_COMPARE_SIGNED |=> signed_ff == $past(pwdata[0]))
      else $error("compare_signed write lost");

   // A hit always lies inside the searched range
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.found |-> COUNT_WIDTH'(rsp_bus.match_index) < entries_ff)
      else $error("match index outside the searched range");

   // A miss carries a zero index
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.found |-> rsp_bus.match_index == '0)
      else $error("miss with nonzero match index");

endmodule

### sim/tb_sorted_table_binary_search.sv
`timescale 1ns / 100ps

module tb_sorted_table_binary_search;
   import stbs_pkg::*;

   // Give up long after the slowest correct run could have finished
   localparam int CYCLE_LIMIT   = 400000;
   // Let writes still queued inside the block retire before touching registers
   localparam int SETTLE_CYCLES = 24;
   // Long stall of the result side, to fill the block and back up its input
   localparam int HOLD_CYCLES   = 300;
   localparam int STIM_ITEMS    = 650;
   localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

   typedef struct packed {
      logic                   found;
      logic [INDEX_WIDTH-1:0] index;
   } match_type;

   logic clock;
   logic reset = 1'b1;

   stbs_req_if req_if ();
   stbs_rsp_if rsp_if ();

   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // Request side: the beat on the bus and its valid
   cmd_type     req_beat  = '0;
   logic        req_valid = 1'b0;
   int unsigned req_gap   = 0;

   // Result side: ready, per-result stall and the long hold-off
   logic        rsp_ready = 1'b0;
   int unsigned rsp_stall = 0;
   int unsigned hold_left = 0;
   logic        hold_kick = 1'b0;

   // Per-phase switches for stretches with no idling at all
   bit sender_calm   = 1'b0;
   bit receiver_calm = 1'b0;

   // Commands waiting to be offered, and results the block still owes
   cmd_type   queued_commands [$];
   match_type expected_matches [$];

   // Mirror of the block: table contents and register settings
   logic [KEY_WIDTH-1:0]   table_words [TABLE_DEPTH_DEFAULT];
   logic [COUNT_WIDTH-1:0] active_count = '0;
   bit                     signed_order = 1'b0;

   // Contents as planned by the stimulus, ahead of the bus
   logic [KEY_WIDTH-1:0] planned_words [TABLE_DEPTH_DEFAULT];

   int unsigned commands_queued = 0;
   int unsigned mismatch_count  = 0;
   int unsigned cycle_count     = 0;

   assign req_if.valid       = req_valid;
   assign req_if.op          = req_beat.op;
   assign req_if.entry_index = req_beat.index;
   assign req_if.key_value   = req_beat.key;
   assign rsp_if.ready       = rsp_ready;

   sorted_table_binary_search u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Report the first few mismatches in full, count the rest
   function automatic void report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endfunction

   // Walk the one-based bounds exactly as the block does: probe entry mid-1,
   // stop on equal, narrow high on a smaller key, raise low on a larger one.
   function automatic match_type search_sorted_words(input logic [KEY_WIDTH-1:0] key);
      match_type            result;
      int unsigned          low;
      int unsigned          high;
      int unsigned          mid;
      logic [KEY_WIDTH-1:0] probe;
      bit                   done;
      bit                   key_below;
      result = '0;
      low    = 1;
      // Counts past the table saturate at its depth
      high   = (active_count > TABLE_DEPTH_DEFAULT) ? TABLE_DEPTH_DEFAULT : active_count;
      done   = (high == 0);
      while (!done && low <= high) begin
         mid   = (low + high) >> 1;
         probe = table_words[mid - 1];
         if (probe === key) begin
            result.found = 1'b1;
            result.index = INDEX_WIDTH'(mid - 1);
            done         = 1'b1;
         end else begin
            key_below = signed_order ? ($signed(key) < $signed(probe)) : (key < probe);
            if (key_below) begin
               high = mid - 1;
            end else begin
               low = mid + 1;
            end
         end
      end
      return result;
   endfunction

   // Apply one accepted beat to the mirror: store a word, or owe a result
   function automatic void take_beat(input cmd_type beat);
      if (beat.op == OP_WRITE) begin
         table_words[beat.index] = beat.key;
      end else begin
         expected_matches.push_back(search_sorted_words(beat.key));
      end
   endfunction

   function automatic void check_match(input logic got_found,
                                       input logic [INDEX_WIDTH-1:0] got_index);
      match_type want;
      if (expected_matches.size() == 0) begin
         report_mismatch($sformatf("result with no search pending: found=%0b index=%0d",
                                   got_found, got_index));
      end else begin
         want = expected_matches.pop_front();
         if (got_found !== want.found) begin
            report_mismatch($sformatf("found: expected %0b, got %0b", want.found, got_found));
         end
         if (got_index !== want.index) begin
            report_mismatch($sformatf("match_index: expected %0d, got %0d",
                                      want.index, got_index));
         end
      end
   endfunction

   // Driver: predict each beat as it is taken, then offer the next one after
   // its drawn gap. Valid gets a single assignment per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_if.ready) begin
            take_beat(req_beat);
         end
         if (!req_valid || req_if.ready) begin
            if (req_gap != 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (queued_commands.size() != 0) begin
               req_beat  <= queued_commands.pop_front();
               req_valid <= 1'b1;
               req_gap   <= sender_calm ? 0 : $urandom_range(0, 18);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat against the oldest owed one, then stall
   // for a drawn number of cycles; the long hold-off overrides ready.
   always @(posedge clock) begin : rsp_monitor
      int unsigned next_stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_if.valid && rsp_ready) begin
            check_match(rsp_if.found, rsp_if.match_index);
            next_stall = receiver_calm ? 0 : $urandom_range(0, 18);
         end else begin
            next_stall = (rsp_stall == 0) ? 0 : rsp_stall - 1;
         end
         rsp_stall <= next_stall;
         rsp_ready <= (next_stall == 0) && (hold_left == 0);
      end
   end

   // Long hold-off of the result side, counted here on its own
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** sorted_table_binary_search: FAILED **");
         $finish;
      end
   end

   // Write one register over APB, then read it back. The register takes the
   // beat at the access edge; upper data bits are random and must be dropped.
   task automatic csr_access(input csr_reg_type sel, input logic [31:0] value);
      logic [31:0] spare;
      logic [31:0] wr_data;
      logic [31:0] rd_want;
      spare = $urandom;
      if (sel == CSR_ENTRIES_IN_USE) begin
         wr_data = {spare[31:9], value[8:0]};
         rd_want = {23'd0, value[8:0]};
      end else begin
         wr_data = {spare[31:1], value[0]};
         rd_want = {31'd0, value[0]};
      end
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= wr_data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (sel == CSR_ENTRIES_IN_USE) begin
         active_count = value[8:0];
      end else begin
         signed_order = value[0];
      end
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== rd_want) begin
         report_mismatch($sformatf("register %s readback: expected %0h, got %0h",
                                   sel.name(), rd_want, csr_prdata));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic queue_write(input int unsigned idx, input logic [31:0] word);
      cmd_type beat;
      beat.op    = OP_WRITE;
      beat.index = INDEX_WIDTH'(idx);
      beat.key   = word;
      planned_words[beat.index] = word;
      queued_commands.push_back(beat);
      commands_queued++;
   endtask

   // The index field means nothing to a search; fill it with noise
   task automatic queue_search(input logic [31:0] key);
      cmd_type beat;
      beat.op    = OP_SEARCH;
      beat.index = INDEX_WIDTH'($urandom);
      beat.key   = key;
      queued_commands.push_back(beat);
      commands_queued++;
   endtask

   // Hold until every command is taken and every owed result is back
   task automatic wait_drained();
      while (queued_commands.size() != 0 || req_valid || expected_matches.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic settle_block();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Load entries 0..n-1 in ascending order for the chosen compare. Mix
   // spread-out words, dense runs with duplicates, and runs across the sign.
   task automatic load_sorted(input int unsigned n, input bit by_sign);
      logic [31:0] words [$];
      logic [31:0] base;
      logic [31:0] word;
      int unsigned style;
      style = $urandom_range(0, 3);
      base  = $urandom;
      for (int i = 0; i < n; i++) begin
         case (style)
            0: word = $urandom;
            1: word = base + $urandom_range(0, 2 * n);
            2: word = SIGN_BIT + $urandom_range(0, 2 * n) - n;
            default: word = $urandom_range(0, 7);
         endcase
         // Flip the sign bit so an unsigned sort gives two's complement order
         words.push_back(by_sign ? (word ^ SIGN_BIT) : word);
      end
      words.sort();
      for (int i = 0; i < n; i++) begin
         queue_write(i, by_sign ? (words[i] ^ SIGN_BIT) : words[i]);
      end
   endtask

   // Mostly keys that sit in the table or just beside an entry, some noise
   function automatic logic [31:0] pick_key(input int unsigned span);
      logic [31:0] key;
      int unsigned roll;
      roll = $urandom_range(0, 19);
      if (span == 0 || roll < 3) begin
         key = $urandom;
      end else if (roll < 5) begin
         case ($urandom_range(0, 3))
            0: key = 32'h0000_0000;
            1: key = 32'hFFFF_FFFF;
            2: key = 32'h7FFF_FFFF;
            default: key = SIGN_BIT;
         endcase
      end else begin
         key = planned_words[$urandom_range(0, span - 1)];
         if (roll < 8) begin
            key = key + 1;
         end else if (roll < 10) begin
            key = key - 1;
         end
      end
      return key;
   endfunction

   // One setting of the registers: write them while idle, optionally reload
   // the searched prefix, then run searches with a sprinkle of stray writes.
   task automatic run_phase(input int unsigned count, input bit by_sign, input bit reload,
                            input int unsigned searches, input bit pause_midway,
                            input bit squeeze);
      int unsigned span;
      span = (count > TABLE_DEPTH_DEFAULT) ? TABLE_DEPTH_DEFAULT : count;
      sender_calm   = squeeze || ($urandom_range(0, 3) == 0);
      receiver_calm = !squeeze && ($urandom_range(0, 3) == 0);
      csr_access(CSR_ENTRIES_IN_USE, count);
      csr_access(CSR_COMPARE_SIGNED, by_sign);
      if (reload) begin
         load_sorted(span, by_sign);
      end
      if (squeeze) begin
         // Let the load go in, then starve the result side while searches pile up
         while (queued_commands.size() != 0) @(posedge clock);
         hold_kick <= 1'b1;
         @(posedge clock);
         hold_kick <= 1'b0;
      end
      for (int s = 0; s < searches; s++) begin
         if (pause_midway && s == searches / 2) begin
            wait_drained();
         end
         // Stray writes may land inside the prefix and break its order
         if ($urandom_range(0, 11) == 0) begin
            queue_write($urandom_range(0, TABLE_DEPTH_DEFAULT - 1), $urandom);
         end
         queue_search(pick_key(span));
      end
      settle_block();
   endtask

   initial begin
      int unsigned count;
      int unsigned roll;
      int unsigned phase_no;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Count of zero straight from reset: no probe, nothing found
      queue_search(32'h0000_0000);
      queue_search(32'hFFFF_FFFF);
      settle_block();

      // Four extreme words in unsigned order: hits at both ends, misses
      csr_access(CSR_ENTRIES_IN_USE, 4);
      csr_access(CSR_COMPARE_SIGNED, 0);
      queue_write(0, 32'h0000_0000);
      queue_write(1, 32'h7FFF_FFFF);
      queue_write(2, 32'h8000_0000);
      queue_write(3, 32'hFFFF_FFFF);
      queue_search(32'h0000_0000);
      queue_search(32'hFFFF_FFFF);
      queue_search(32'h8000_0000);
      queue_search(32'h7FFF_FFFF);
      queue_search(32'h0000_0005);
      queue_search(32'h8000_0001);
      settle_block();

      // Same words compared signed: the table is now out of order
      csr_access(CSR_COMPARE_SIGNED, 1);
      queue_search(32'h8000_0000);
      queue_search(32'hFFFF_FFFF);
      queue_search(32'h0000_0001);
      settle_block();

      // Single entry; a write at the last index stays outside the search
      csr_access(CSR_ENTRIES_IN_USE, 1);
      queue_write(TABLE_DEPTH_DEFAULT - 1, 32'h5A5A_5A5A);
      queue_search(32'h0000_0000);
      queue_search(32'h5A5A_5A5A);
      settle_block();

      // Full table in signed order while the result side stalls for long
      run_phase(TABLE_DEPTH_DEFAULT, 1'b1, 1'b1, 40, 1'b0, 1'b1);
      // Counts past the table saturate; reuse the full load
      run_phase(511, 1'b1, 1'b0, 20, 1'b0, 1'b0);
      run_phase(300, 1'b0, 1'b0, 12, 1'b0, 1'b0);

      phase_no = 0;
      while (commands_queued < STIM_ITEMS) begin
         roll = $urandom_range(0, 9);
         if (phase_no == 0 || roll == 0) begin
            count = 0;
         end else if (roll == 1) begin
            count = $urandom_range(25, 120);
         end else begin
            count = $urandom_range(1, 24);
         end
         run_phase(count, $urandom_range(0, 1), count != 0, $urandom_range(12, 30),
                   phase_no == 1 || $urandom_range(0, 3) == 0, 1'b0);
         phase_no++;
      end

      settle_block();
      if (mismatch_count == 0 && expected_matches.size() == 0) begin
         $display("** sorted_table_binary_search: PASSED **");
      end else begin
         $display("** sorted_table_binary_search: FAILED **");
      end
      $finish;
   end

endmodule
